// ----- sv/gregorian_date_arithmetic_top_assert.svh -----
// Assertion macros for the date arithmetic unit checker.
// Depends on a clock named aclk and an active-low reset named aresetn in scope.
`ifndef GREGORIAN_DATE_ARITHMETIC_TOP_ASSERT_SVH
`define GREGORIAN_DATE_ARITHMETIC_TOP_ASSERT_SVH

// clocked check, off during reset
`define GDA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// check that a condition implies another in the same cycle
`define GDA_ASSERT_IMP(lbl, cond, prop, msg) \
    `GDA_ASSERT(lbl, (cond) |-> (prop), msg)

`endif

// ----- sv/gda_pkg.sv -----
// Shared types, codes, reciprocal constants and small tables for the date unit.
// No dependencies.
package gda_pkg;

    localparam logic [1:0] OP_ADD  = 2'd0;
    localparam logic [1:0] OP_SUB  = 2'd1;
    localparam logic [1:0] OP_DIFF = 2'd2;

    localparam logic [21:0] GAP_MAX   = 22'h3FFFFF;
    localparam logic [17:0] DAYS_ERA  = 18'd146097;
    localparam logic [17:0] DOE_LAST  = 18'd146096;
    localparam logic [13:0] YEAR_MAX  = 14'd9999;
    localparam logic [14:0] YEAR_BIAS = 15'd400;

    localparam logic [15:0] M_DIV100  = 16'(((64'd1 << 22) + 64'd99) / 64'd100);
    localparam logic [23:0] M_DIVERA  = 24'(((64'd1 << 41) + 64'd146096) / 64'd146097);
    localparam logic [18:0] M_DIV1460 = 19'(((64'd1 << 29) + 64'd1459) / 64'd1460);
    localparam logic [18:0] M_DIV36524 = 19'(((64'd1 << 34) + 64'd36523) / 64'd36524);
    localparam logic [18:0] M_DIV365  = 19'(((64'd1 << 27) + 64'd364) / 64'd365);
    localparam logic [9:0]  M_DIV100S = 10'(((64'd1 << 16) + 64'd99) / 64'd100);
    localparam logic [11:0] M_DIV153  = 12'(((64'd1 << 19) + 64'd152) / 64'd153);

    typedef struct packed {
        logic [1:0]  op;
        logic        keep;
        logic [4:0]  kd;
        logic [3:0]  km;
        logic [13:0] ky;
        logic [21:0] gap;
    } gda_ctl_t;

    function automatic logic [3:0] clamp_month(input logic [3:0] m);
        logic [3:0] r;
        r = m;
        if (m == 4'd0) r = 4'd1;
        else if (m > 4'd12) r = 4'd12;
        return r;
    endfunction

    // day of year at the start of a March-based month
    function automatic logic [8:0] month_start(input logic [3:0] mp);
        logic [8:0] r;
        case (mp)
            4'd0:    r = 9'd0;
            4'd1:    r = 9'd31;
            4'd2:    r = 9'd61;
            4'd3:    r = 9'd92;
            4'd4:    r = 9'd122;
            4'd5:    r = 9'd153;
            4'd6:    r = 9'd184;
            4'd7:    r = 9'd214;
            4'd8:    r = 9'd245;
            4'd9:    r = 9'd275;
            4'd10:   r = 9'd306;
            4'd11:   r = 9'd337;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

endpackage

// ----- sv/gda_d2s.sv -----
// Date to day-serial front end: decode, year/100 reciprocal, serial sum.
// Depends on gda_pkg.
module gda_d2s import gda_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic             in_valid,
    input  logic [1:0]       op,
    input  logic [4:0]       day,
    input  logic [3:0]       month,
    input  logic [13:0]      year,
    input  logic [15:0]      day_count,
    input  logic [4:0]       other_day,
    input  logic [3:0]       other_month,
    input  logic [13:0]      other_year,
    output logic             out_valid,
    output gda_ctl_t         out_ctl,
    output logic [22:0]      z1,
    output logic [22:0]      z2
);

    logic [2:0] v_reg;

    gda_ctl_t           a_ctl_next, a_ctl_reg, b_ctl_reg, c_ctl_reg;
    logic [3:0]         a_mp1_next, a_mp2_next, a_mp1_reg, a_mp2_reg, b_mp1_reg, b_mp2_reg;
    logic [14:0]        a_ya1_next, a_ya2_next, a_ya1_reg, a_ya2_reg, b_ya1_reg, b_ya2_reg;
    logic signed [17:0] a_off1_next, a_off2_next, a_off1_reg, a_off2_reg;
    logic signed [17:0] b_off1_reg, b_off2_reg;
    logic [7:0]         b_q1_next, b_q2_next, b_q1_reg, b_q2_reg;
    logic [22:0]        c_z1_next, c_z2_next, c_z1_reg, c_z2_reg;
    logic [3:0]         m1, m2;
    logic signed [17:0] dp;
    logic [30:0]        p1, p2;

    function automatic logic [22:0] serial(input logic [14:0] ya, input logic [7:0] q,
                                           input logic [3:0] mp, input logic signed [17:0] off);
        logic [24:0] s;
        s = 25'(ya) * 25'd365 + 25'(ya >> 2) + 25'(q >> 2) + 25'(month_start(mp)) - 25'(q)
            + {{7{off[17]}}, off};
        return s[22:0];
    endfunction

    always_comb begin
        m1 = clamp_month(month);
        m2 = clamp_month(other_month);
        a_mp1_next = (m1 > 4'd2) ? m1 - 4'd3 : m1 + 4'd9;
        a_mp2_next = (m2 > 4'd2) ? m2 - 4'd3 : m2 + 4'd9;
        a_ya1_next = {1'b0, year} + YEAR_BIAS - 15'(m1 <= 4'd2);
        a_ya2_next = {1'b0, other_year} + YEAR_BIAS - 15'(m2 <= 4'd2);
        case (op)
            OP_ADD:  dp = $signed({13'd0, day}) + $signed({2'd0, day_count});
            OP_SUB:  dp = $signed({13'd0, day}) - $signed({2'd0, day_count});
            default: dp = $signed({13'd0, day});
        endcase
        a_off1_next = dp - 18'sd1;
        a_off2_next = $signed({13'd0, other_day}) - 18'sd1;
        a_ctl_next.op   = op;
        a_ctl_next.keep = ((op == OP_ADD) && (dp == 18'sd0)) || ((op == OP_SUB) && (dp > 18'sd0));
        a_ctl_next.kd   = dp[4:0];
        a_ctl_next.km   = m1;
        a_ctl_next.ky   = year;
        a_ctl_next.gap  = '0;
        p1 = 31'(a_ya1_reg) * 31'(M_DIV100);
        p2 = 31'(a_ya2_reg) * 31'(M_DIV100);
        b_q1_next = p1[29:22];
        b_q2_next = p2[29:22];
        c_z1_next = serial(b_ya1_reg, b_q1_reg, b_mp1_reg, b_off1_reg);
        c_z2_next = serial(b_ya2_reg, b_q2_reg, b_mp2_reg, b_off2_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_ctl_reg  <= a_ctl_next;
            a_mp1_reg  <= a_mp1_next;
            a_mp2_reg  <= a_mp2_next;
            a_ya1_reg  <= a_ya1_next;
            a_ya2_reg  <= a_ya2_next;
            a_off1_reg <= a_off1_next;
            a_off2_reg <= a_off2_next;
            b_ctl_reg  <= a_ctl_reg;
            b_mp1_reg  <= a_mp1_reg;
            b_mp2_reg  <= a_mp2_reg;
            b_ya1_reg  <= a_ya1_reg;
            b_ya2_reg  <= a_ya2_reg;
            b_off1_reg <= a_off1_reg;
            b_off2_reg <= a_off2_reg;
            b_q1_reg   <= b_q1_next;
            b_q2_reg   <= b_q2_next;
            c_ctl_reg  <= b_ctl_reg;
            c_z1_reg   <= c_z1_next;
            c_z2_reg   <= c_z2_next;
        end
    end

    assign out_valid = v_reg[2];
    assign out_ctl   = c_ctl_reg;
    assign z1        = c_z1_reg;
    assign z2        = c_z2_reg;

endmodule

// ----- sv/gda_s2d.sv -----
// Day-serial to date back end and gap: 400-year era split, year of era, month, day.
// Depends on gda_pkg.
module gda_s2d import gda_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_valid,
    input  gda_ctl_t           in_ctl,
    input  logic [22:0]        z1,
    input  logic [22:0]        z2,
    output logic               out_valid,
    output gda_ctl_t           out_ctl,
    output logic [4:0]         res_d,
    output logic [3:0]         res_m,
    output logic signed [15:0] res_y
);

    logic [6:0] v_reg;
    gda_ctl_t   ctl_reg [7];

    logic [22:0] d_z_reg;
    logic [5:0]  d_era_next, d_era_reg, e_era_reg, f_era_reg, g_era_reg, i_era_reg, j_era_reg;
    logic [21:0] d_gap_next;
    logic [17:0] e_doe_next, e_doe_reg, f_doe_reg, g_doe_reg;
    logic [7:0]  f_q1_next, f_q1_reg;
    logic [2:0]  f_q2_next, f_q2_reg;
    logic        f_last_reg;
    logic [8:0]  g_yoe_next, g_yoe_reg, i_yoe_reg, j_yoe_reg;
    logic [8:0]  i_doy_next, i_doy_reg, j_doy_reg;
    logic [3:0]  j_mp_next, j_mp_reg;
    logic [4:0]  k_d_next, k_d_reg;
    logic [3:0]  k_m_next, k_m_reg;
    logic signed [15:0] k_y_next, k_y_reg;
    gda_ctl_t    d_ctl_next;

    logic [23:0] diff;
    logic [46:0] pe;
    logic [36:0] p1, p2, p3;
    logic [17:0] t;
    logic [18:0] p4;
    logic [17:0] doy_w;
    logic [10:0] x153;
    logic [22:0] p5;

    always_comb begin
        diff = {1'b0, z1} - {1'b0, z2};
        if (diff[23]) diff = -diff;
        d_gap_next = (diff > 24'(GAP_MAX)) ? GAP_MAX : diff[21:0];
        d_ctl_next = in_ctl;
        d_ctl_next.gap = (in_ctl.op == OP_DIFF) ? d_gap_next : '0;
        pe = 47'(z1) * 47'(M_DIVERA);
        d_era_next = pe[46:41];

        e_doe_next = 18'(d_z_reg - 23'(d_era_reg) * 23'(DAYS_ERA));

        p1 = 37'(e_doe_reg) * 37'(M_DIV1460);
        p2 = 37'(e_doe_reg) * 37'(M_DIV36524);
        f_q1_next = p1[36:29];
        f_q2_next = p2[36:34];

        t  = f_doe_reg - 18'(f_q1_reg) + 18'(f_q2_reg) - 18'(f_last_reg);
        p3 = 37'(t) * 37'(M_DIV365);
        g_yoe_next = p3[35:27];

        p4    = 19'(g_yoe_reg) * 19'(M_DIV100S);
        doy_w = g_doe_reg - 18'(g_yoe_reg) * 18'd365 - 18'(g_yoe_reg >> 2) + 18'(p4[18:16]);
        i_doy_next = doy_w[8:0];

        x153 = 11'(i_doy_reg) * 11'd5 + 11'd2;
        p5   = 23'(x153) * 23'(M_DIV153);
        j_mp_next = p5[22:19];

        k_d_next = 5'(j_doy_reg - month_start(j_mp_reg) + 9'd1);
        k_m_next = (j_mp_reg < 4'd10) ? j_mp_reg + 4'd3 : j_mp_reg - 4'd9;
        k_y_next = $signed(16'(j_era_reg) * 16'd400 + 16'(j_yoe_reg)
                   + 16'(k_m_next <= 4'd2)) - 16'sd400;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= {v_reg[5:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ctl_reg[0] <= d_ctl_next;
            for (int i = 1; i < 7; i++) ctl_reg[i] <= ctl_reg[i-1];
            d_z_reg    <= z1;
            d_era_reg  <= d_era_next;
            e_doe_reg  <= e_doe_next;
            e_era_reg  <= d_era_reg;
            f_doe_reg  <= e_doe_reg;
            f_era_reg  <= e_era_reg;
            f_q1_reg   <= f_q1_next;
            f_q2_reg   <= f_q2_next;
            f_last_reg <= (e_doe_reg == DOE_LAST);
            g_doe_reg  <= f_doe_reg;
            g_era_reg  <= f_era_reg;
            g_yoe_reg  <= g_yoe_next;
            i_doy_reg  <= i_doy_next;
            i_era_reg  <= g_era_reg;
            i_yoe_reg  <= g_yoe_reg;
            j_doy_reg  <= i_doy_reg;
            j_era_reg  <= i_era_reg;
            j_yoe_reg  <= i_yoe_reg;
            j_mp_reg   <= j_mp_next;
            k_d_reg    <= k_d_next;
            k_m_reg    <= k_m_next;
            k_y_reg    <= k_y_next;
        end
    end

    assign out_valid = v_reg[6];
    assign out_ctl   = ctl_reg[6];
    assign res_d     = k_d_reg;
    assign res_m     = k_m_reg;
    assign res_y     = k_y_reg;

endmodule

// ----- sv/gregorian_date_arithmetic_top.sv -----
// Gregorian date unit: add or subtract days, or day gap between two dates.
// One item enters per cycle through s_valid/s_ready; one result leaves per item
// through m_valid/m_ready, in order.
// An input transfer passes through 3 stages that turn each date into a day serial,
// 7 stages that turn the serial back into a date through reciprocal-multiply
// divisions, and 1 output stage before m_valid.
// Throughput is one item per cycle while the output is not stalled; no walk over months is done.
// Add and subtract go through the serial unless the date needs no walk, in
// which case the given month and year pass through with the new day. Results outside years 1..9999 are
// pinned to the nearest end with m_out_of_range set.
// Reset (aresetn low at a clock edge) empties the pipeline; no result appears.
// When the receiver holds m_ready low with a result waiting, the whole pipeline
// freezes, s_ready drops, and nothing is lost or repeated.
// Depends on gda_pkg, gda_d2s and gda_s2d.
module gregorian_date_arithmetic_top import gda_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_op,
    input  logic [4:0]  s_day,
    input  logic [3:0]  s_month,
    input  logic [13:0] s_year,
    input  logic [15:0] s_day_count,
    input  logic [4:0]  s_other_day,
    input  logic [3:0]  s_other_month,
    input  logic [13:0] s_other_year,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [4:0]  m_res_day,
    output logic [3:0]  m_res_month,
    output logic [13:0] m_res_year,
    output logic [21:0] m_gap_days,
    output logic        m_out_of_range
);

    logic               en;
    logic               d2s_valid, s2d_valid;
    gda_ctl_t           d2s_ctl, s2d_ctl;
    logic [22:0]        z1, z2;
    logic [4:0]         cd;
    logic [3:0]         cm;
    logic signed [15:0] cy;

    logic        m_valid_reg;
    logic [4:0]  day_next, day_reg;
    logic [3:0]  month_next, month_reg;
    logic [13:0] year_next, year_reg;
    logic [21:0] gap_next, gap_reg;
    logic        oor_next, oor_reg;
    logic        lo, hi;

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    gda_d2s u_d2s (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .en          (en),
        .in_valid    (s_valid),
        .op          (s_op),
        .day         (s_day),
        .month       (s_month),
        .year        (s_year),
        .day_count   (s_day_count),
        .other_day   (s_other_day),
        .other_month (s_other_month),
        .other_year  (s_other_year),
        .out_valid   (d2s_valid),
        .out_ctl     (d2s_ctl),
        .z1          (z1),
        .z2          (z2)
    );

    gda_s2d u_s2d (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (d2s_valid),
        .in_ctl    (d2s_ctl),
        .z1        (z1),
        .z2        (z2),
        .out_valid (s2d_valid),
        .out_ctl   (s2d_ctl),
        .res_d     (cd),
        .res_m     (cm),
        .res_y     (cy)
    );

    always_comb begin
        day_next   = '0;
        month_next = '0;
        year_next  = '0;
        gap_next   = '0;
        oor_next   = 1'b0;
        if (s2d_ctl.keep) begin
            lo = (s2d_ctl.ky == 14'd0);
            hi = (s2d_ctl.ky > YEAR_MAX);
        end else begin
            lo = (cy < 16'sd1);
            hi = (cy > $signed({2'b00, YEAR_MAX}));
        end
        case (s2d_ctl.op)
            OP_ADD, OP_SUB: begin
                if (lo) begin
                    day_next   = 5'd1;
                    month_next = 4'd1;
                    year_next  = 14'd1;
                    oor_next   = 1'b1;
                end else if (hi) begin
                    day_next   = 5'd31;
                    month_next = 4'd12;
                    year_next  = YEAR_MAX;
                    oor_next   = 1'b1;
                end else if (s2d_ctl.keep) begin
                    day_next   = s2d_ctl.kd;
                    month_next = s2d_ctl.km;
                    year_next  = s2d_ctl.ky;
                end else begin
                    day_next   = cd;
                    month_next = cm;
                    year_next  = cy[13:0];
                end
            end
            OP_DIFF: begin
                gap_next = s2d_ctl.gap;
            end
            default: begin
                gap_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= s2d_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            day_reg   <= day_next;
            month_reg <= month_next;
            year_reg  <= year_next;
            gap_reg   <= gap_next;
            oor_reg   <= oor_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_res_day      = day_reg;
    assign m_res_month    = month_reg;
    assign m_res_year     = year_reg;
    assign m_gap_days     = gap_reg;
    assign m_out_of_range = oor_reg;

endmodule

// ----- sv/gda_chk.sv -----
// Port-level checker for the date unit, bound to the top level.
// Depends on gregorian_date_arithmetic_top_assert.svh.
`include "gregorian_date_arithmetic_top_assert.svh"
module gda_chk (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [4:0]  m_res_day,
    input logic [3:0]  m_res_month,
    input logic [13:0] m_res_year,
    input logic [21:0] m_gap_days,
    input logic        m_out_of_range
);

    `GDA_ASSERT(a_hold, m_valid && !m_ready |=> m_valid && $stable(m_res_year) && $stable(m_gap_days), "stalled transfer changed")
    `GDA_ASSERT_IMP(a_pin, m_valid && m_out_of_range, (m_res_year == 14'd1 && m_res_month == 4'd1 && m_res_day == 5'd1) || (m_res_year == 14'd9999 && m_res_month == 4'd12 && m_res_day == 5'd31), "out of range date not pinned")
    `GDA_ASSERT_IMP(a_gap, m_valid && m_gap_days != 22'd0, m_res_year == 14'd0 && !m_out_of_range, "gap with date fields")
    `GDA_ASSERT_IMP(a_mon, m_valid && m_res_year != 14'd0, m_res_month != 4'd0 && m_res_month <= 4'd12, "bad month")

endmodule

bind gregorian_date_arithmetic_top gda_chk u_gda_chk (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_res_day      (m_res_day),
    .m_res_month    (m_res_month),
    .m_res_year     (m_res_year),
    .m_gap_days     (m_gap_days),
    .m_out_of_range (m_out_of_range)
);
